@@ rtl/i2cts_pkg.sv @@
package i2cts_pkg;

	localparam int unsigned ADDR_W   = 7;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned REG_COUNT = 4;

	localparam logic [ADDR_W-1:0] ADDR_RST_0 = 7'h48;
	localparam logic [ADDR_W-1:0] ADDR_RST_1 = 7'h49;
	localparam logic [ADDR_W-1:0] ADDR_RST_2 = 7'h4A;
	localparam logic [ADDR_W-1:0] ADDR_RST_3 = 7'h4B;
	localparam logic              READ_BIT   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_ADDR_0 = 3'd0,
		REG_SENSOR_ADDR_1 = 3'd1,
		REG_SENSOR_ADDR_2 = 3'd2,
		REG_SENSOR_ADDR_3 = 3'd3
	} reg_idx_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_EVENT = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_SEND_ADR = 4'd1,
		PH_CHECK    = 4'd2,
		PH_GET_HI   = 4'd3,
		PH_ASK_LO   = 4'd4,
		PH_GET_LO   = 4'd5,
		PH_STOP     = 4'd6,
		PH_NEXT     = 4'd7
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_RECV  = 3'd3,
		CMD_ACK   = 3'd4,
		CMD_NACK  = 3'd5,
		CMD_STOP  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		CAP_NONE = 2'd0,
		CAP_HI   = 2'd1,
		CAP_LO   = 2'd2
	} cap_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [7:0]       tx;
		cap_t             kind;
		logic [IDX_W-1:0] who;
		logic [7:0]       data;
		logic             anack;
		logic             done;
	} result_t;

endpackage

@@ rtl/i2c_temp_sensor_poll_sequencer.sv @@
// Poll sequencer for a two-byte temperature read from up to SENSOR_COUNT sensors over an
// I2C master. Each accepted input transfer (a start request or a step-complete event from
// the bus engine) yields exactly one result transfer carrying the next bus command, the
// address byte to send, any captured temperature byte, and the address-NACK and scan-done
// flags. The phase update is a single register step, and a one-deep output register lets
// a new item be accepted every cycle while out_ready is high. The user must write sensor
// addresses through the cfg port only while the block is idle; the block does not check.
module i2c_temp_sensor_poll_sequencer #(
	parameter int unsigned SENSOR_COUNT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [i2cts_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [i2cts_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic                             ack_status,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       bus_command,
	output logic [7:0]                       tx_byte,
	output logic [1:0]                       capture_kind,
	output logic [1:0]                       sensor_number,
	output logic [7:0]                       data_byte,
	output logic                             addr_nack,
	output logic                             scan_done
);

	localparam logic [i2cts_pkg::IDX_W:0] LAST_NEXT = (i2cts_pkg::IDX_W+1)'(SENSOR_COUNT);

	logic [i2cts_pkg::ADDR_W-1:0] addr_q [i2cts_pkg::REG_COUNT];
	i2cts_pkg::phase_t            phase_q, phase_d;
	logic [i2cts_pkg::IDX_W-1:0]  idx_q, idx_d;
	i2cts_pkg::result_t           res_d, res_q;
	logic                         out_valid_q;
	logic                         take;
	logic [i2cts_pkg::IDX_W:0]    who_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q[0] <= i2cts_pkg::ADDR_RST_0;
			addr_q[1] <= i2cts_pkg::ADDR_RST_1;
			addr_q[2] <= i2cts_pkg::ADDR_RST_2;
			addr_q[3] <= i2cts_pkg::ADDR_RST_3;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				i2cts_pkg::REG_SENSOR_ADDR_0: addr_q[0] <= cfg_data;
				i2cts_pkg::REG_SENSOR_ADDR_1: addr_q[1] <= cfg_data;
				i2cts_pkg::REG_SENSOR_ADDR_2: addr_q[2] <= cfg_data;
				i2cts_pkg::REG_SENSOR_ADDR_3: addr_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cts_pkg::PH_IDLE;
			idx_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		who_inc = {1'b0, idx_q} + (i2cts_pkg::IDX_W+1)'(1);
		phase_d = phase_q;
		idx_d   = idx_q;
		res_d   = '{cmd: i2cts_pkg::CMD_NONE, tx: 8'h00, kind: i2cts_pkg::CAP_NONE,
			who: idx_q, data: 8'h00, anack: 1'b0, done: 1'b0};
		if (op == i2cts_pkg::OP_START) begin
			idx_d     = '0;
			res_d.who = '0;
			res_d.cmd = i2cts_pkg::CMD_START;
			phase_d   = i2cts_pkg::PH_SEND_ADR;
		end else begin
			unique case (phase_q)
				i2cts_pkg::PH_SEND_ADR: begin
					res_d.cmd = i2cts_pkg::CMD_WRITE;
					res_d.tx  = {addr_q[idx_q], i2cts_pkg::READ_BIT};
					phase_d   = i2cts_pkg::PH_CHECK;
				end
				i2cts_pkg::PH_CHECK: begin
					if (ack_status) begin
						res_d.cmd   = i2cts_pkg::CMD_STOP;
						res_d.anack = 1'b1;
						phase_d     = i2cts_pkg::PH_NEXT;
					end else begin
						res_d.cmd = i2cts_pkg::CMD_RECV;
						phase_d   = i2cts_pkg::PH_GET_HI;
					end
				end
				i2cts_pkg::PH_GET_HI: begin
					res_d.kind = i2cts_pkg::CAP_HI;
					res_d.data = rx_byte;
					res_d.cmd  = i2cts_pkg::CMD_ACK;
					phase_d    = i2cts_pkg::PH_ASK_LO;
				end
				i2cts_pkg::PH_ASK_LO: begin
					res_d.cmd = i2cts_pkg::CMD_RECV;
					phase_d   = i2cts_pkg::PH_GET_LO;
				end
				i2cts_pkg::PH_GET_LO: begin
					res_d.kind = i2cts_pkg::CAP_LO;
					res_d.data = rx_byte;
					res_d.cmd  = i2cts_pkg::CMD_NACK;
					phase_d    = i2cts_pkg::PH_STOP;
				end
				i2cts_pkg::PH_STOP: begin
					res_d.cmd = i2cts_pkg::CMD_STOP;
					phase_d   = i2cts_pkg::PH_NEXT;
				end
				i2cts_pkg::PH_NEXT: begin
					if (who_inc < LAST_NEXT) begin
						idx_d     = who_inc[i2cts_pkg::IDX_W-1:0];
						res_d.who = who_inc[i2cts_pkg::IDX_W-1:0];
						res_d.cmd = i2cts_pkg::CMD_START;
						phase_d   = i2cts_pkg::PH_SEND_ADR;
					end else begin
						idx_d      = '0;
						res_d.done = 1'b1;
						phase_d    = i2cts_pkg::PH_IDLE;
					end
				end
				default: phase_d = i2cts_pkg::PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign bus_command   = res_q.cmd;
	assign tx_byte       = res_q.tx;
	assign capture_kind  = res_q.kind;
	assign sensor_number = res_q.who;
	assign data_byte     = res_q.data;
	assign addr_nack     = res_q.anack;
	assign scan_done     = res_q.done;

endmodule
